### rtl/core/jsu_pkg.sv
// jsu_pkg: types, codes and helpers for the json string unescape block
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int unsigned JsuFifoDepth = 4;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX1    = 4'd3,
    PH_WANT_BS = 4'd4,
    PH_WANT_U  = 4'd5,
    PH_HEX2    = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_NO_OPEN    = 4'd1,
    ERR_CONTROL    = 4'd2,
    ERR_BAD_ESC    = 4'd3,
    ERR_BAD_HEX    = 4'd4,
    ERR_HI_UNPAIR  = 4'd5,
    ERR_NOT_LOW    = 4'd6,
    ERR_LONE_LOW   = 4'd7,
    ERR_ENDED      = 4'd8
  } err_e;

  // what the back end has to do with one queue entry
  typedef enum logic [1:0] {
    ENT_BYTE  = 2'd0,
    ENT_CP    = 2'd1,
    ENT_CLOSE = 2'd2,
    ENT_ERR   = 2'd3
  } ent_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       error_code;
    logic       last;
  } out_t;

  typedef struct packed {
    ent_e        op;
    err_e        code;
    logic [20:0] cp;
  } ent_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChU      = 8'h75;

  // bit 4 set when the byte is a hex digit, low nibble is its value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/jsu_front.sv
// jsu_front: string state machine, one input word per cycle while accept_i is high, one queue entry at most
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire jsu_pkg::in_t in_i,
  output jsu_pkg::ent_t     ent_o,
  output logic              ent_valid_o
);

  jsu_pkg::phase_e phase_q, phase_d, phase_c;
  logic [1:0]  hex_cnt_q, hex_cnt_d, hex_cnt_c;
  logic [15:0] first_q, first_d, first_c;
  logic [15:0] acc_q, acc_d, acc_c;
  logic [15:0] acc_new;
  logic [4:0]  hd;
  logic [7:0]  b;
  logic [9:0]  hi_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= jsu_pkg::PH_IDLE;
      hex_cnt_q <= 2'd0;
      first_q   <= 16'd0;
      acc_q     <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      first_q   <= first_d;
      acc_q     <= acc_d;
    end
  end

  assign b       = in_i.in_byte;
  assign hd      = jsu_pkg::hex_val(b);
  assign acc_new = {acc_c[11:0], hd[3:0]};
  assign hi_off  = (first_c < 16'hd800) ? 10'd0 : first_c[9:0];

  always_comb begin
    phase_c   = in_i.restart ? jsu_pkg::PH_IDLE : phase_q;
    hex_cnt_c = in_i.restart ? 2'd0 : hex_cnt_q;
    first_c   = in_i.restart ? 16'd0 : first_q;
    acc_c     = in_i.restart ? 16'd0 : acc_q;
    phase_d     = phase_q;
    hex_cnt_d   = hex_cnt_q;
    first_d     = first_q;
    acc_d       = acc_q;
    ent_valid_o = 1'b0;
    ent_o.op    = jsu_pkg::ENT_BYTE;
    ent_o.code  = jsu_pkg::ERR_NONE;
    ent_o.cp    = 21'd0;
    if (accept_i) begin
      phase_d   = phase_c;
      hex_cnt_d = hex_cnt_c;
      first_d   = first_c;
      acc_d     = acc_c;
      if (in_i.end_of_input) begin
        ent_valid_o = 1'b1;
        ent_o.op    = jsu_pkg::ENT_ERR;
        ent_o.code  = (phase_c == jsu_pkg::PH_IDLE) ? jsu_pkg::ERR_NO_OPEN
                                                    : jsu_pkg::ERR_ENDED;
      end else begin
        case (phase_c)
          jsu_pkg::PH_IDLE: begin
            if (b == jsu_pkg::ChQuote) begin
              phase_d = jsu_pkg::PH_STR;
            end else if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0d))) begin
              ent_valid_o = 1'b1;
              ent_o.op    = jsu_pkg::ENT_ERR;
              ent_o.code  = jsu_pkg::ERR_NO_OPEN;
            end
          end
          jsu_pkg::PH_STR: begin
            if (b == jsu_pkg::ChQuote) begin
              ent_valid_o = 1'b1;
              ent_o.op    = jsu_pkg::ENT_CLOSE;
              phase_d     = jsu_pkg::PH_IDLE;
            end else if (b == jsu_pkg::ChBslash) begin
              phase_d = jsu_pkg::PH_ESC;
            end else if (b < 8'h20) begin
              ent_valid_o = 1'b1;
              ent_o.op    = jsu_pkg::ENT_ERR;
              ent_o.code  = jsu_pkg::ERR_CONTROL;
            end else begin
              ent_valid_o = 1'b1;
              ent_o.cp    = {13'd0, b};
            end
          end
          jsu_pkg::PH_ESC: begin
            phase_d     = jsu_pkg::PH_STR;
            ent_valid_o = 1'b1;
            case (b)
              jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash: ent_o.cp = {13'd0, b};
              8'h62: ent_o.cp = 21'h08;
              8'h66: ent_o.cp = 21'h0c;
              8'h6e: ent_o.cp = 21'h0a;
              8'h72: ent_o.cp = 21'h0d;
              8'h74: ent_o.cp = 21'h09;
              jsu_pkg::ChU: begin
                ent_valid_o = 1'b0;
                phase_d     = jsu_pkg::PH_HEX1;
                hex_cnt_d   = 2'd0;
                acc_d       = 16'd0;
              end
              default: begin
                ent_o.op   = jsu_pkg::ENT_ERR;
                ent_o.code = jsu_pkg::ERR_BAD_ESC;
              end
            endcase
          end
          jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
            if (!hd[4]) begin
              ent_valid_o = 1'b1;
              ent_o.op    = jsu_pkg::ENT_ERR;
              ent_o.code  = jsu_pkg::ERR_BAD_HEX;
            end else if (hex_cnt_c != 2'd3) begin
              hex_cnt_d = hex_cnt_c + 2'd1;
              acc_d     = acc_new;
            end else begin
              hex_cnt_d = 2'd0;
              acc_d     = 16'd0;
              if (phase_c == jsu_pkg::PH_HEX1) begin
                if (acc_new >= 16'hd800 && acc_new <= 16'hdbff) begin
                  first_d = acc_new;
                  phase_d = jsu_pkg::PH_WANT_BS;
                end else if (acc_new >= 16'hdc00 && acc_new <= 16'hdfff) begin
                  ent_valid_o = 1'b1;
                  ent_o.op    = jsu_pkg::ENT_ERR;
                  ent_o.code  = jsu_pkg::ERR_LONE_LOW;
                end else begin
                  ent_valid_o = 1'b1;
                  ent_o.op    = jsu_pkg::ENT_CP;
                  ent_o.cp    = {5'd0, acc_new};
                  phase_d     = jsu_pkg::PH_STR;
                end
              end else begin
                if (acc_new < 16'hdc00 || acc_new > 16'hdfff) begin
                  ent_valid_o = 1'b1;
                  ent_o.op    = jsu_pkg::ENT_ERR;
                  ent_o.code  = jsu_pkg::ERR_NOT_LOW;
                end else begin
                  ent_valid_o = 1'b1;
                  ent_o.op    = jsu_pkg::ENT_CP;
                  ent_o.cp    = 21'h10000 + {1'b0, hi_off, acc_new[9:0]};
                  phase_d     = jsu_pkg::PH_STR;
                  first_d     = 16'd0;
                end
              end
            end
          end
          jsu_pkg::PH_WANT_BS: begin
            if (b == jsu_pkg::ChBslash) begin
              phase_d = jsu_pkg::PH_WANT_U;
            end else begin
              ent_valid_o = 1'b1;
              ent_o.op    = jsu_pkg::ENT_ERR;
              ent_o.code  = jsu_pkg::ERR_HI_UNPAIR;
            end
          end
          jsu_pkg::PH_WANT_U: begin
            if (b == jsu_pkg::ChU) begin
              phase_d   = jsu_pkg::PH_HEX2;
              hex_cnt_d = 2'd0;
              acc_d     = 16'd0;
            end else begin
              ent_valid_o = 1'b1;
              ent_o.op    = jsu_pkg::ENT_ERR;
              ent_o.code  = jsu_pkg::ERR_HI_UNPAIR;
            end
          end
          default: begin
            phase_d   = jsu_pkg::PH_IDLE;
            hex_cnt_d = 2'd0;
            first_d   = 16'd0;
            acc_d     = 16'd0;
          end
        endcase
      end
      // any error sends the machine home with cleared scratch state
      if (ent_valid_o && ent_o.op == jsu_pkg::ENT_ERR) begin
        phase_d   = jsu_pkg::PH_IDLE;
        hex_cnt_d = 2'd0;
        first_d   = 16'd0;
        acc_d     = 16'd0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/jsu_fifo.sv
// jsu_fifo: small register queue of decoded entries between front and back
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::JsuFifoDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire jsu_pkg::ent_t wdata_i,
  input  wire logic          rd_i,
  output jsu_pkg::ent_t      rdata_o,
  output logic               full_o,
  output logic               valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jsu_pkg::ent_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/jsu_back.sv
// jsu_back: expands queue entries into result words, utf-8 encoding included
// depends on jsu_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire jsu_pkg::ent_t ent_i,
  input  wire logic          ent_valid_i,
  output logic               ent_pop_o,
  input  wire logic          pop,
  output logic               empty,
  output jsu_pkg::out_t      out_o
);

  logic [1:0] idx_q;
  logic [1:0] nlast;
  logic [7:0] byte_sel;
  logic       load, take, is_last;
  logic       ovalid_q;
  jsu_pkg::out_t out_q, word;
  logic [20:0] cp;

  assign cp = ent_i.cp;

  always_comb begin
    nlast    = 2'd0;
    byte_sel = 8'd0;
    case (ent_i.op)
      jsu_pkg::ENT_BYTE: byte_sel = cp[7:0];
      jsu_pkg::ENT_CP: begin
        if (cp <= 21'h7f) begin
          byte_sel = cp[7:0];
        end else if (cp <= 21'h7ff) begin
          nlast    = 2'd1;
          byte_sel = (idx_q == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
          nlast = 2'd2;
          case (idx_q)
            2'd0:    byte_sel = {4'he, cp[15:12]};
            2'd1:    byte_sel = {2'b10, cp[11:6]};
            default: byte_sel = {2'b10, cp[5:0]};
          endcase
        end else begin
          nlast = 2'd3;
          case (idx_q)
            2'd0:    byte_sel = {5'b11110, cp[20:18]};
            2'd1:    byte_sel = {2'b10, cp[17:12]};
            2'd2:    byte_sel = {2'b10, cp[11:6]};
            default: byte_sel = {2'b10, cp[5:0]};
          endcase
        end
      end
      default: byte_sel = 8'd0;
    endcase
  end

  always_comb begin
    word.out_byte   = byte_sel;
    word.error_code = jsu_pkg::ERR_NONE;
    word.last       = is_last;
    case (ent_i.op)
      jsu_pkg::ENT_CLOSE: word.kind = jsu_pkg::KIND_CLOSE;
      jsu_pkg::ENT_ERR: begin
        word.kind       = jsu_pkg::KIND_ERR;
        word.error_code = ent_i.code;
      end
      default: word.kind = jsu_pkg::KIND_BYTE;
    endcase
  end

  assign is_last   = (idx_q == nlast);
  assign load      = !ovalid_q || pop;
  assign take      = load && ent_valid_i;
  assign ent_pop_o = take && is_last;
  assign empty     = !ovalid_q;
  assign out_o     = out_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      if (take) begin
        ovalid_q <= 1'b1;
        idx_q    <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop) begin
        ovalid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/json_string_unescape_utf8.sv
// json_string_unescape_utf8: top level, front decoder, entry queue and result back end
// depends on jsu_pkg, jsu_front, jsu_fifo, jsu_back
//
//   channel   handshake        payload
//   input     push / full      in_i  (in_byte, end_of_input, restart)
//   result    empty / pop      out_o (out_byte, kind, error_code, last)
//
// the front takes one input word per cycle while the entry queue has room
// a code point of n utf-8 bytes leaves as n result words from the back end, one per cycle while pop keeps up
// results pass through the entry queue and then the result register before they appear
// full rises only when the entry queue holds FifoDepth entries; a stalled pop backs it up
// reset clears the decoder state, the queue pointers and count, and the result valid flag at once
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int unsigned FifoDepth = jsu_pkg::JsuFifoDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire jsu_pkg::in_t in_i,
  output logic              empty,
  input  wire logic         pop,
  output jsu_pkg::out_t     out_o
);

  jsu_pkg::ent_t ent_w, ent_r;
  logic ent_wr, ent_rd, ent_valid, q_full, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .ent_o       (ent_w),
    .ent_valid_o (ent_wr)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ent_wr),
    .wdata_i (ent_w),
    .rd_i    (ent_rd),
    .rdata_o (ent_r),
    .full_o  (q_full),
    .valid_o (ent_valid)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (ent_r),
    .ent_valid_i (ent_valid),
    .ent_pop_o   (ent_rd),
    .pop         (pop),
    .empty       (empty),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### dv/tb_top.sv
// tb_top: self-checking bench for json_string_unescape_utf8
// directed table then random json strings, checked against a local decoder model
// depends on jsu_pkg and the json_string_unescape_utf8 rtl only
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam logic [15:0] SurHiLo = 16'hd800;
  localparam logic [15:0] SurHiHi = 16'hdbff;
  localparam logic [15:0] SurLoLo = 16'hdc00;
  localparam logic [15:0] SurLoHi = 16'hdfff;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned WordsPerPhase = 64;
  localparam int NumRows = 26;

  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_QUIET   = 2'd1,
    ROW_ONE     = 2'd2
  } row_form_e;

  typedef struct packed {
    in_t       w;
    row_form_e form;
    out_t      res;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_t       in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_t      out_word;
  row_form_e row_form = ROW_PREDICT;
  out_t      row_res = '0;

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned fed_count = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned closes_seen = 0;
  int unsigned errors_seen = 0;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;

  // decoder model state
  phase_e      dec_phase;
  logic [1:0]  dec_nibbles;
  logic [15:0] dec_high_unit;
  logic [15:0] dec_acc;
  out_t        step_q[$];
  out_t        expected_q[$];

  row_t dir_rows [NumRows];

  json_string_unescape_utf8 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_word),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_word)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= "0" && c <= "9") begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end
    if (lc >= "a" && lc <= "f") begin
      v = lc - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  task automatic clear_decoder();
    dec_phase = PH_IDLE;
    dec_nibbles = 2'd0;
    dec_high_unit = 16'h0000;
    dec_acc = 16'h0000;
  endtask

  task automatic put_result(input logic [7:0] b, input kind_e k, input err_e e);
    out_t r;
    r.out_byte = b;
    r.kind = k;
    r.error_code = e;
    r.last = 1'b0;
    step_q = {step_q, r};
  endtask

  task automatic give_error(input err_e e);
    put_result(8'h00, KIND_ERR, e);
    clear_decoder();
  endtask

  task automatic put_code_point(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      put_result(cp[7:0], KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'h7ff) begin
      put_result({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
      put_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else if (cp <= 21'hffff) begin
      put_result({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
      put_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
      put_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else begin
      put_result({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
      put_result({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
      put_result({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
      put_result({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end
  endtask

  // results of one input word land in step_q, last flag on the final one
  task automatic decode_word(input in_t w);
    logic [4:0]  hx;
    logic [15:0] unit;
    logic [7:0]  b;
    b = w.in_byte;
    step_q.delete();
    if (w.restart) clear_decoder();
    if (w.end_of_input) begin
      give_error(dec_phase == PH_IDLE ? ERR_NO_OPEN : ERR_ENDED);
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (b == ChQuote) dec_phase = PH_STR;
          else if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0d))) give_error(ERR_NO_OPEN);
        end
        PH_STR: begin
          if (b == ChQuote) begin
            put_result(8'h00, KIND_CLOSE, ERR_NONE);
            dec_phase = PH_IDLE;
          end else if (b == ChBslash) begin
            dec_phase = PH_ESC;
          end else if (b < 8'h20) begin
            give_error(ERR_CONTROL);
          end else begin
            put_result(b, KIND_BYTE, ERR_NONE);
          end
        end
        PH_ESC: begin
          dec_phase = PH_STR;
          case (b)
            ChQuote, ChBslash, ChSlash: put_result(b, KIND_BYTE, ERR_NONE);
            "b": put_result(8'h08, KIND_BYTE, ERR_NONE);
            "f": put_result(8'h0c, KIND_BYTE, ERR_NONE);
            "n": put_result(8'h0a, KIND_BYTE, ERR_NONE);
            "r": put_result(8'h0d, KIND_BYTE, ERR_NONE);
            "t": put_result(8'h09, KIND_BYTE, ERR_NONE);
            ChU: begin
              dec_phase = PH_HEX1;
              dec_nibbles = 2'd0;
              dec_acc = 16'h0000;
            end
            default: give_error(ERR_BAD_ESC);
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          hx = hex_nibble(b);
          if (!hx[4]) begin
            give_error(ERR_BAD_HEX);
          end else begin
            dec_acc = {dec_acc[11:0], hx[3:0]};
            if (dec_nibbles != 2'd3) begin
              dec_nibbles = dec_nibbles + 2'd1;
            end else begin
              dec_nibbles = 2'd0;
              unit = dec_acc;
              dec_acc = 16'h0000;
              if (dec_phase == PH_HEX1) begin
                if (unit >= SurHiLo && unit <= SurHiHi) begin
                  dec_high_unit = unit;
                  dec_phase = PH_WANT_BS;
                end else if (unit >= SurLoLo && unit <= SurLoHi) begin
                  give_error(ERR_LONE_LOW);
                end else begin
                  put_code_point({5'd0, unit});
                  dec_phase = PH_STR;
                end
              end else if (unit < SurLoLo || unit > SurLoHi) begin
                give_error(ERR_NOT_LOW);
              end else begin
                put_code_point(21'h10000 + {1'b0, dec_high_unit[9:0], unit[9:0]});
                dec_phase = PH_STR;
                dec_high_unit = 16'h0000;
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (b == ChBslash) dec_phase = PH_WANT_U;
          else give_error(ERR_HI_UNPAIR);
        end
        PH_WANT_U: begin
          if (b == ChU) begin
            dec_phase = PH_HEX2;
            dec_nibbles = 2'd0;
            dec_acc = 16'h0000;
          end else begin
            give_error(ERR_HI_UNPAIR);
          end
        end
        default: clear_decoder();
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input out_t got, input out_t want);
    mismatches++;
    $display("%0t mismatch, %s: got byte %h kind %0d code %0d last %b, want byte %h kind %0d code %0d last %b",
             $time, what, got.out_byte, got.kind, got.error_code, got.last,
             want.out_byte, want.kind, want.error_code, want.last);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    words_out++;
    if (got.kind == KIND_CLOSE) closes_seen++;
    if (got.kind == KIND_ERR) errors_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected word", got, '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
        got.error_code !== want.error_code || got.last !== want.last) begin
      report_mismatch("wrong word", got, want);
    end
  endtask

  // sample both handshakes at the edge, predict before checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        words_in++;
        decode_word(in_word);
        if (row_form == ROW_ONE) begin
          expected_q = {expected_q, row_res};
        end else if (row_form == ROW_PREDICT) begin
          expected_q = {expected_q, step_q};
        end
      end
      if (pop && !empty) check_result(out_word);
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99, 0) >= pop_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t watchdog: no word moved for %0d cycles", $time, StuckLimit);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic drive_word(input in_t w, input row_form_e form, input out_t res);
    push <= 1'b1;
    in_word <= w;
    row_form <= form;
    row_res <= res;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic in_t plain(input logic [7:0] b);
    return '{in_byte: b, end_of_input: 1'b0, restart: 1'b0};
  endfunction

  task automatic feed(input in_t w);
    drive_word(w, ROW_PREDICT, '0);
    fed_count++;
  endtask

  // backslash, u and the top n hex digits of v, random letter case
  task automatic feed_unit(input logic [15:0] v, input int unsigned n);
    logic [3:0] nib;
    logic [7:0] c;
    feed(plain(ChBslash));
    feed(plain(ChU));
    for (int unsigned i = 0; i < n; i++) begin
      nib = v[15:12];
      v = v << 4;
      if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
      else c = ($urandom_range(1, 0) ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
      feed(plain(c));
    end
  endtask

  task automatic feed_piece(input bit broken);
    logic [7:0] b;
    logic [15:0] v;
    logic [4:0] hx;
    in_t w;
    if (!broken) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3: begin
          b = 8'($urandom_range(255, 32));
          if (b == ChQuote || b == ChBslash) b = 8'h7e;
          feed(plain(b));
        end
        4, 5: begin
          case ($urandom_range(7, 0))
            0: b = ChQuote;
            1: b = ChBslash;
            2: b = ChSlash;
            3: b = "b";
            4: b = "f";
            5: b = "n";
            6: b = "r";
            default: b = "t";
          endcase
          feed(plain(ChBslash));
          feed(plain(b));
        end
        6, 7, 8: begin
          case ($urandom_range(3, 0))
            0: v = 16'($urandom_range(16'h7f, 0));
            1: v = 16'($urandom_range(16'h7ff, 16'h80));
            2: v = 16'($urandom_range(16'hffff, 16'h800));
            default: v = 16'h0000;
          endcase
          if (v >= SurHiLo && v <= SurLoHi) v = v ^ 16'h4000;
          feed_unit(v, 4);
        end
        default: begin
          feed_unit(16'($urandom_range(SurHiHi, SurHiLo)), 4);
          feed_unit(16'($urandom_range(SurLoHi, SurLoLo)), 4);
        end
      endcase
    end else begin
      case ($urandom_range(8, 0))
        0: feed(plain(8'($urandom_range(31, 0))));
        1: begin
          b = 8'($urandom);
          if (b == ChQuote || b == ChBslash || b == ChSlash || b == ChU || b == "b" ||
              b == "f" || b == "n" || b == "r" || b == "t") b = "q";
          feed(plain(ChBslash));
          feed(plain(b));
        end
        2: begin
          b = 8'($urandom);
          hx = hex_nibble(b);
          if (hx[4]) b = "g";
          feed_unit(16'($urandom), $urandom_range(3, 0));
          feed(plain(b));
        end
        3: feed_unit(16'($urandom_range(SurLoHi, SurLoLo)), 4);
        4: begin
          feed_unit(16'($urandom_range(SurHiHi, SurHiLo)), 4);
          b = 8'($urandom);
          if ($urandom_range(1, 0) == 0) begin
            if (b == ChBslash) b = "x";
            feed(plain(b));
          end else begin
            if (b == ChU) b = "x";
            feed(plain(ChBslash));
            feed(plain(b));
          end
        end
        5: begin
          feed_unit(16'($urandom_range(SurHiHi, SurHiLo)), 4);
          v = 16'($urandom);
          if (v >= SurLoLo && v <= SurLoHi) v = v ^ 16'h4000;
          feed_unit(v, 4);
        end
        6: begin
          // end of text at some depth of the string
          case ($urandom_range(5, 0))
            0: ;
            1: feed(plain(ChBslash));
            2: feed_unit(16'($urandom), $urandom_range(3, 0));
            3: feed_unit(16'($urandom_range(SurHiHi, SurHiLo)), 4);
            4: begin
              feed_unit(16'($urandom_range(SurHiHi, SurHiLo)), 4);
              feed(plain(ChBslash));
            end
            default: begin
              feed_unit(16'($urandom_range(SurHiHi, SurHiLo)), 4);
              feed_unit(16'($urandom), $urandom_range(3, 0));
            end
          endcase
          w = plain(8'($urandom));
          w.end_of_input = 1'b1;
          feed(w);
        end
        7: begin
          w = plain(8'($urandom));
          w.restart = 1'b1;
          w.end_of_input = ($urandom_range(3, 0) == 0);
          feed(w);
        end
        default: feed(plain(8'($urandom)));
      endcase
    end
  endtask

  task automatic feed_string();
    int unsigned segs;
    int unsigned fault_at;
    logic [7:0] ws;
    repeat ($urandom_range(2, 0)) begin
      ws = ($urandom_range(5, 0) == 5) ? 8'h20 : 8'($urandom_range(8'h0d, 8'h09));
      drive_word(plain(ws), ROW_PREDICT, '0);
    end
    if ($urandom_range(15, 0) == 0) feed(plain(8'($urandom)));
    if ($urandom_range(19, 0) == 0) feed('{in_byte: 8'($urandom), end_of_input: 1'b1,
                                           restart: 1'b0});
    feed(plain(ChQuote));
    segs = $urandom_range(8, 0);
    fault_at = ($urandom_range(3, 0) == 0) ? $urandom_range(segs, 0) : segs + 1;
    for (int unsigned i = 0; i < segs; i++) begin
      if (i == fault_at) begin
        feed_piece(1'b1);
        return;
      end
      feed_piece(1'b0);
    end
    if (fault_at == segs) feed_piece(1'b1);
    else feed(plain(ChQuote));
  endtask

  function automatic row_t mk(input logic [7:0] b, input logic eoi, input logic rs,
                              input row_form_e f, input kind_e k, input err_e e,
                              input logic [7:0] ob);
    row_t r;
    r.w = '{in_byte: b, end_of_input: eoi, restart: rs};
    r.form = f;
    r.res = '{out_byte: ob, kind: k, error_code: e, last: 1'b1};
    return r;
  endfunction

  initial begin
    dir_rows = '{
      mk(8'h00,    1'b1, 1'b0, ROW_ONE,     KIND_ERR,   ERR_NO_OPEN, 8'h00),
      mk(8'hff,    1'b1, 1'b1, ROW_ONE,     KIND_ERR,   ERR_NO_OPEN, 8'h00),
      mk("x",      1'b0, 1'b0, ROW_ONE,     KIND_ERR,   ERR_NO_OPEN, 8'h00),
      mk(8'h0d,    1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(ChQuote,  1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(8'hff,    1'b0, 1'b0, ROW_ONE,     KIND_BYTE,  ERR_NONE,    8'hff),
      mk(8'h1f,    1'b0, 1'b0, ROW_ONE,     KIND_ERR,   ERR_CONTROL, 8'h00),
      mk(ChQuote,  1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(ChBslash, 1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("q",      1'b0, 1'b0, ROW_ONE,     KIND_ERR,   ERR_BAD_ESC, 8'h00),
      mk(ChQuote,  1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(ChBslash, 1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(ChU,      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("D",      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("b",      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("F",      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("f",      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(ChBslash, 1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(ChU,      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("d",      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("F",      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("F",      1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk("F",      1'b0, 1'b0, ROW_PREDICT, KIND_BYTE,  ERR_NONE,    8'h00),
      mk(8'h00,    1'b1, 1'b0, ROW_ONE,     KIND_ERR,   ERR_ENDED,   8'h00),
      mk(ChQuote,  1'b0, 1'b0, ROW_QUIET,   KIND_BYTE,  ERR_NONE,    8'h00),
      mk(ChQuote,  1'b0, 1'b0, ROW_ONE,     KIND_CLOSE, ERR_NONE,    8'h00)
    };
    clear_decoder();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumRows; i++) begin
      drive_word(dir_rows[i].w, dir_rows[i].form, dir_rows[i].res);
    end
    // idling phases: none, sender gaps, receiver stalls, light on both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 6 : 0;
      pop_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 6 : 0;
      fed_count = 0;
      while (fed_count < WordsPerPhase) feed_string();
    end
    push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("run covered %0d input words and %0d result words", words_in, words_out);
    $display("  of which %0d string closes and %0d errors, %0d mismatches",
             closes_seen, errors_seen, mismatches);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
